// ----- rtl/cmwc_pkg.sv -----
// ----------------------------------------------------------------------------
// CMWC package
// Shared constants, types and helper functions for the bounded CMWC
// random generator.
// ----------------------------------------------------------------------------
package cmwc_pkg;

  // Lag table geometry.
  localparam int LAG_SIZE   = 4096;
  localparam int IDX_W      = $clog2(LAG_SIZE);
  localparam int SEED_IDX_W = 12;

  // Datapath widths.
  localparam int WORD_W  = 32;
  localparam int MULT_W  = 16;
  localparam int CARRY_W = 16;
  localparam int T_W     = MULT_W + WORD_W;

  // Rejection sampling limit.
  localparam int STEP_LIMIT = 256;
  localparam int TRY_W      = $clog2(STEP_LIMIT);

  // Reset and arithmetic constants.
  localparam logic [CARRY_W-1:0] CARRY_INIT = CARRY_W'(123);
  localparam logic [MULT_W-1:0]  MULT_RESET = MULT_W'(18782);
  localparam logic [WORD_W-1:0]  WORD_BASE  = 32'hFFFF_FFFE;
  localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(LAG_SIZE - 1);

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_MULT = 1'b0;

  // Request codes.
  localparam logic REQ_DRAW = 1'b0;
  localparam logic REQ_SEED = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_WB,
    ST_DONE
  } state_t;

  // Set every bit below the top set bit.
  function automatic logic [WORD_W-1:0] smear(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] s;
    s = v;
    s = s | (s >> 1);
    s = s | (s >> 2);
    s = s | (s >> 4);
    s = s | (s >> 8);
    s = s | (s >> 16);
    return s;
  endfunction

  // Next table position with wrap after the last entry.
  function automatic logic [IDX_W-1:0] pos_inc(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] n;
    n = (p == LAST_IDX) ? '0 : p + 1'b1;
    return n;
  endfunction

endpackage

// ----- rtl/cmwc_bounded_random_generator.sv -----
// ----------------------------------------------------------------------------
// CMWC bounded random generator
// Complementary multiply-with-carry generator over a lag table in RAM, with
// rejection sampling of each word against an inclusive bound.
// ----------------------------------------------------------------------------
// A seed item is taken in the idle state. A draw item needs n generator steps (1 to
// 256); the block takes no new item until the draw's result has left the done state,
// so draws do not overlap.
// A step is a table RAM read with multiply, then the carry fold and write-back.
// A stalled result holds the block in its done state. Reset sets position to
// the last entry, carry to 123 and the multiplier to 18782; the table is not cleared.
module cmwc_bounded_random_generator (
  input  logic                                   clk,
  input  logic                                   rst,
  // Input item channel.
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   req_type,
  input  logic [cmwc_pkg::WORD_W-1:0]            offset,
  input  logic [cmwc_pkg::WORD_W-1:0]            span,
  input  logic [cmwc_pkg::SEED_IDX_W-1:0]        seed_index,
  input  logic [cmwc_pkg::WORD_W-1:0]            seed_value,
  // Result item channel.
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [cmwc_pkg::WORD_W-1:0]            value,
  // Configuration port.
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [cmwc_pkg::PADDR_W-1:0]           paddr,
  input  logic [cmwc_pkg::PDATA_W-1:0]           pwdata,
  output logic [cmwc_pkg::PDATA_W-1:0]           prdata,
  output logic                                   pready
);

  import cmwc_pkg::*;

  state_t state, state_next;

  logic [MULT_W-1:0]  multiplier;
  logic [IDX_W-1:0]   position;
  logic [CARRY_W-1:0] carry;
  logic [IDX_W-1:0]   rd_idx;
  logic [TRY_W-1:0]   tries;
  logic               chk_pend;

  logic [WORD_W-1:0]  span_q;
  logic [WORD_W-1:0]  span_mask;
  logic [WORD_W-1:0]  offset_q;
  logic [T_W-1:0]     t_reg;
  logic [WORD_W-1:0]  step_word;
  logic [WORD_W-1:0]  res;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;

  logic               in_take;
  logic               draw_start;
  logic               seed_wr;
  logic               out_free;
  logic               finish;
  logic               step_ok;
  logic [WORD_W-1:0]  masked;
  logic [WORD_W-1:0]  raw;

  logic [CARRY_W-1:0] c_hi;
  logic [WORD_W:0]    fold;
  logic               fold_ovf;
  logic [CARRY_W-1:0] carry_next;
  logic [WORD_W-1:0]  word_next;

  logic               cfg_wr;

  // Lag table storage.
  cmwc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (LAG_SIZE)
  ) u_lag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration port: single multiplier register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[PADDR_W-1] == REG_MULT);
  assign prdata = (paddr[PADDR_W-1] == REG_MULT) ? PDATA_W'(multiplier) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      multiplier <= MULT_RESET;
    end else if (cfg_wr) begin
      multiplier <= pwdata[MULT_W-1:0];
    end
  end

  // Carry fold of one step: x = t + c, bump both when the sum wraps.
  assign c_hi       = t_reg[T_W-1:WORD_W];
  assign fold       = {1'b0, t_reg[WORD_W-1:0]} + (WORD_W+1)'(c_hi);
  assign fold_ovf   = fold[WORD_W];
  assign carry_next = c_hi + CARRY_W'(fold_ovf);
  assign word_next  = (fold_ovf ? (WORD_BASE - 1'b1) : WORD_BASE) - fold[WORD_W-1:0];

  // Rejection check of the previous step's word.
  assign masked  = step_word & span_mask;
  assign step_ok = (masked <= span_q);
  assign raw     = step_ok ? masked : span_q;
  assign finish  = chk_pend && (step_ok || (tries == TRY_W'(STEP_LIMIT - 1)));

  assign out_free = !out_valid || !out_stall;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && (req_type == REQ_DRAW)) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = finish ? ST_DONE : ST_WB;
      end
      ST_WB: begin
        state_next = ST_MUL;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output and RAM control logic.
  always_comb begin
    in_stall   = 1'b1;
    in_take    = 1'b0;
    draw_start = 1'b0;
    seed_wr    = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = rd_idx;
    ram_wdata  = word_next;
    ram_raddr  = pos_inc(position);
    case (state)
      ST_IDLE: begin
        in_stall   = 1'b0;
        in_take    = in_valid;
        draw_start = in_valid && (req_type == REQ_DRAW);
        seed_wr    = in_valid && (req_type == REQ_SEED)
                     && ({1'b0, seed_index} < (SEED_IDX_W+1)'(LAG_SIZE));
        ram_we     = seed_wr;
        ram_waddr  = IDX_W'(seed_index);
        ram_wdata  = seed_value;
      end
      ST_WB: begin
        ram_we    = 1'b1;
        ram_raddr = pos_inc(rd_idx);
      end
      ST_MUL, ST_DONE: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      position  <= LAST_IDX;
      carry     <= CARRY_INIT;
      tries     <= '0;
      chk_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // A seed puts the generator back to its start.
      if (in_take && (req_type == REQ_SEED)) begin
        position <= LAST_IDX;
        carry    <= CARRY_INIT;
      end
      if (draw_start) begin
        tries    <= '0;
        chk_pend <= 1'b0;
      end
      // Commit a generator step.
      if (state == ST_WB) begin
        position <= rd_idx;
        carry    <= carry_next;
        chk_pend <= 1'b1;
      end
      if ((state == ST_MUL) && chk_pend && !finish) begin
        tries <= tries + 1'b1;
      end
      // Result register.
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (draw_start) begin
      span_q    <= span;
      span_mask <= smear(span);
      offset_q  <= offset;
    end
    // Track the table entry whose read is in flight.
    if (draw_start) begin
      rd_idx <= pos_inc(position);
    end else if (state == ST_WB) begin
      rd_idx <= pos_inc(rd_idx);
    end
    if (state == ST_MUL) begin
      t_reg <= T_W'(multiplier) * T_W'(ram_rdata) + T_W'(carry);
    end
    if (state == ST_WB) begin
      step_word <= word_next;
    end
    if ((state == ST_MUL) && finish) begin
      res <= raw + offset_q;
    end
    if ((state == ST_DONE) && out_free) begin
      value <= res;
    end
  end

  // A step commit moves the position onto the entry just written.
  a_pos_commit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WB) |=> (position == $past(rd_idx)))
    else $error("position does not follow the written table entry");

  // The table is written by a step only in the write-back state.
  a_step_write: assert property (@(posedge clk) disable iff (rst)
    (ram_we && (state != ST_IDLE)) |-> (state == ST_WB))
    else $error("table write outside write-back");

  // A draw ends once the step limit is reached.
  a_step_limit: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_MUL) && chk_pend && (tries == TRY_W'(STEP_LIMIT - 1)))
    |=> (state == ST_DONE))
    else $error("draw ran past the step limit");

  // A result appears only from the done state.
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("result item raised outside the done state");

endmodule

// ----- rtl/cmwc_ram.sv -----
// ----------------------------------------------------------------------------
// CMWC RAM
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module cmwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- tb/sv/cmwc_bounded_random_generator_test.sv -----
// ----------------------------------------------------------------------------
// CMWC bounded random generator testbench
// Seeds the low part of the lag table that the draws reach, then drives
// directed and random draw and seed items. The expected values come from a
// CMWC model that runs inside the bench. The multiplier register is set to
// several values over the APB port and read back. Each phase uses a different
// idling pattern on the two channels, and one phase holds the result side off
// for a long stretch.
// ----------------------------------------------------------------------------
module cmwc_bounded_random_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cmwc_pkg::*;

  typedef struct {
    logic                  kind;
    logic [WORD_W-1:0]     offset;
    logic [WORD_W-1:0]     span;
    logic [SEED_IDX_W-1:0] index;
    logic [WORD_W-1:0]     word;
  } gen_request_t;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  localparam logic [PADDR_W-1:0] MULT_ADDR = PADDR_W'(4 * REG_MULT);
  localparam int HOLD_CYCLES = 400;
  localparam int SEED_COUNT = 384;
  localparam int PHASE_ITEMS = 75;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = REQ_DRAW;
  logic [WORD_W-1:0] offset = '0;
  logic [WORD_W-1:0] span = '0;
  logic [SEED_IDX_W-1:0] seed_index = '0;
  logic [WORD_W-1:0] seed_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [WORD_W-1:0] value;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // Bench copy of the generator state.
  logic [WORD_W-1:0]  lag_words [LAG_SIZE];
  logic [IDX_W-1:0]   gen_pos = LAST_IDX;
  logic [CARRY_W-1:0] gen_carry = CARRY_INIT;
  logic [MULT_W-1:0]  mult_value = MULT_RESET;

  gen_request_t      pending_requests [$];
  logic [WORD_W-1:0] expected_values [$];
  idle_mode_t        idle_mode = IDLE_NONE;
  logic              hold_armed = 1'b0;
  logic              hold_done = 1'b0;
  int                hold_left = 0;
  int                errors = 0;
  int                cfg_errors = 0;

  cmwc_bounded_random_generator i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .offset     (offset),
    .span       (span),
    .seed_index (seed_index),
    .seed_value (seed_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value      (value),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // One CMWC step: advance the position, fold the carry, write the table.
  function automatic logic [WORD_W-1:0] cmwc_advance();
    logic [IDX_W-1:0]  p;
    logic [63:0]       prod;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] x;
    p = (gen_pos == LAG_SIZE - 1) ? '0 : gen_pos + 1'b1;
    prod = 64'(mult_value) * 64'(lag_words[p]) + 64'(gen_carry);
    c = prod[63:32];
    x = prod[31:0] + c;
    if (x < c) begin
      x = x + 1'b1;
      c = c + 1'b1;
    end
    lag_words[p] = WORD_BASE - x;
    gen_pos = p;
    gen_carry = c[CARRY_W-1:0];
    return lag_words[p];
  endfunction

  // Bounded draw by rejection; gives up after the step limit and takes span.
  function automatic logic [WORD_W-1:0] cmwc_draw(input logic [WORD_W-1:0] add,
                                                   input logic [WORD_W-1:0] bound);
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] raw;
    logic              found;
    found = 1'b0;
    raw = '0;
    for (int b = 0; b < WORD_W; b++) begin
      mask[b] = (bound >> b) != 0;
    end
    for (int tries = 0; tries < STEP_LIMIT && !found; tries++) begin
      raw = cmwc_advance() & mask;
      if (raw <= bound) begin
        found = 1'b1;
      end
    end
    if (!found) begin
      raw = bound;
    end
    return raw + add;
  endfunction

  function automatic void cmwc_seed(input logic [SEED_IDX_W-1:0] idx,
                                    input logic [WORD_W-1:0] word);
    if (idx < LAG_SIZE) begin
      lag_words[idx] = word;
    end
    gen_pos = LAST_IDX;
    gen_carry = CARRY_INIT;
  endfunction

  function automatic logic idle_roll(input logic sender);
    int pct;
    pct = 0;
    if (idle_mode == IDLE_BOTH) begin
      pct = 21;
    end else if (sender && idle_mode == IDLE_SENDER) begin
      pct = 52;
    end else if (!sender && idle_mode == IDLE_RECEIVER) begin
      pct = 52;
    end
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic void queue_item(input logic kind, input logic [WORD_W-1:0] add,
                                     input logic [WORD_W-1:0] bound,
                                     input logic [SEED_IDX_W-1:0] idx,
                                     input logic [WORD_W-1:0] word);
    gen_request_t r;
    r.kind = kind;
    r.offset = add;
    r.span = bound;
    r.index = idx;
    r.word = word;
    pending_requests.push_back(r);
  endfunction

  // Random mix: mostly draws over varied bounds, some reseeding of entries.
  task automatic queue_random(input int count);
    logic [WORD_W-1:0]     bound;
    logic [WORD_W-1:0]     add;
    logic [SEED_IDX_W-1:0] idx;
    int                    k;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 31);
      case ($urandom_range(0, 5))
        0: bound = $urandom_range(0, 15);
        1: bound = $urandom;
        2: bound = 32'h1 << k;
        3: bound = (32'h1 << k) - 1;
        4: bound = (32'h1 << k) + $urandom_range(0, 3);
        default: bound = $urandom >> k;
      endcase
      case ($urandom_range(0, 7))
        0: add = '0;
        1: add = '1;
        default: add = $urandom;
      endcase
      case ($urandom_range(0, 9))
        0: idx = '0;
        1: idx = LAST_IDX;
        default: idx = SEED_IDX_W'($urandom_range(0, LAG_SIZE - 1));
      endcase
      queue_item($urandom_range(0, 99) < 15 ? REQ_SEED : REQ_DRAW, add, bound, idx,
                 $urandom);
    end
  endtask

  // Wait until all items are taken and all results are back, then let the
  // block finish any seed item still in work. The falling edge is used so
  // that the driver and monitor updates of the rising edge have settled.
  task automatic wait_idle();
    while (pending_requests.size() != 0 || in_valid || expected_values.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic check_multiplier(input logic [MULT_W-1:0] want);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= MULT_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== PDATA_W'(want)) begin
      if (errors + cfg_errors < 10) begin
        $display("multiplier readback: expected %h, got %h", PDATA_W'(want), prdata);
      end
      cfg_errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_multiplier(input logic [MULT_W-1:0] m);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MULT_ADDR;
    pwdata <= PDATA_W'(m);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    mult_value = m;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    check_multiplier(m);
  endtask

  // Request driver: holds an item until it is taken, idles at random.
  always @(posedge clk) begin : drive_requests
    gen_request_t next_req;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_requests.size() != 0 && !idle_roll(1'b1)) begin
        next_req = pending_requests.pop_front();
        in_valid <= 1'b1;
        req_type <= next_req.kind;
        offset <= next_req.offset;
        span <= next_req.span;
        seed_index <= next_req.index;
        seed_value <= next_req.word;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side stall: random, plus one long hold-off when armed.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (hold_armed && !hold_done) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end
      out_stall <= (hold_left > 1) || (hold_armed && !hold_done) || idle_roll(1'b0);
    end
  end

  // Monitor: check taken results, then predict for each taken request.
  always @(posedge clk) begin : check_results
    logic [WORD_W-1:0] want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_values.size() == 0) begin
          if (errors + cfg_errors < 10) begin
            $display("unexpected result item: got %h", value);
          end
          errors++;
        end else begin
          want = expected_values.pop_front();
          if (value !== want) begin
            if (errors + cfg_errors < 10) begin
              $display("value mismatch: expected %h, got %h", want, value);
            end
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (req_type == REQ_SEED) begin
          cmwc_seed(seed_index, seed_value);
        end else begin
          expected_values.push_back(cmwc_draw(offset, span));
        end
      end
    end
  end

  // Main sequence.
  initial begin : run_phases
    logic [MULT_W-1:0] phase_mult [4];
    idle_mode_t        phase_mode [4];
    phase_mult = '{16'hFFFF, MULT_RESET, MULT_W'($urandom_range(1, 65535)),
                   MULT_W'($urandom_range(2, 65534))};
    phase_mode = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    check_multiplier(MULT_RESET);
    write_multiplier(MULT_W'(1));

    // Seed the low entries, well past the furthest position a run of draws
    // reaches between reseeds. The first 256 get small words so that, with a
    // multiplier of one, the first draw rejects until the step limit.
    for (int i = 0; i < SEED_COUNT; i++) begin
      queue_item(REQ_SEED, $urandom, $urandom, SEED_IDX_W'(i),
                 i < 256 ? ($urandom & 32'h3FFF_FFFF) : $urandom);
    end
    wait_idle();

    // Directed items.
    queue_item(REQ_DRAW, 32'h1234_5678, 32'h8000_0000, '0, '0);
    queue_item(REQ_DRAW, 32'hFFFF_FFFF, 32'h0000_0000, '1, '1);
    queue_item(REQ_DRAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0);
    queue_item(REQ_DRAW, 32'h0000_0000, 32'h0000_0001, '0, '0);
    queue_item(REQ_DRAW, 32'h8000_0000, 32'h7FFF_FFFF, '0, '0);
    queue_item(REQ_SEED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF);
    queue_item(REQ_DRAW, 32'h0000_0000, 32'hFFFF_FFFF, '0, '0);
    queue_item(REQ_SEED, 32'h0000_0000, 32'h0000_0000, LAST_IDX, 32'h0000_0000);
    queue_item(REQ_DRAW, 32'h0000_0001, 32'h8000_0000, '0, '0);
    queue_item(REQ_DRAW, 32'h0000_0000, 32'h0000_0003, '0, '0);
    queue_item(REQ_DRAW, 32'h7FFF_FFFF, 32'h0000_0004, '0, '0);
    queue_item(REQ_DRAW, 32'h8000_0001, 32'h0001_0000, '0, '0);
    queue_item(REQ_SEED, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 12'hA5A, 32'h5A5A_5A5A);
    queue_item(REQ_DRAW, 32'h0000_0010, 32'h0000_FFFF, '0, '0);
    wait_idle();

    // Random phases, each with its own multiplier and idling pattern.
    for (int k = 0; k < 4; k++) begin
      write_multiplier(phase_mult[k]);
      idle_mode <= phase_mode[k];
      @(posedge clk);
      queue_random(PHASE_ITEMS);
      if (k == 0) begin
        hold_armed <= 1'b1;
      end
      wait_idle();
    end

    repeat (40) @(posedge clk);
    if (errors + cfg_errors + expected_values.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Limit on the whole run.
  initial begin
    #8ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
